>>> design/pidl_pkg.sv
package pidl_pkg;

   localparam int DEPTH  = 64;
   localparam int CNT_W  = 7;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2
   } status_type;

   // per-cell steering control
   typedef struct packed {
      logic load;        // take the new value
      logic from_left;   // shift up: take lower neighbor
      logic from_right;  // shift down: take upper neighbor
      logic tap;         // present held value on the removal tap
   } cell_ctl_type;

endpackage

>>> design/pidl_cell.sv
module pidl_cell (
   input  logic                               clock,
   input  pidl_pkg::cell_ctl_type             ctl,
   input  logic signed [pidl_pkg::DATA_W-1:0] item_value,
   input  logic signed [pidl_pkg::DATA_W-1:0] left_value,
   input  logic signed [pidl_pkg::DATA_W-1:0] right_value,
   output logic signed [pidl_pkg::DATA_W-1:0] entry_value,
   output logic signed [pidl_pkg::DATA_W-1:0] tap_value
);

   logic signed [pidl_pkg::DATA_W-1:0] entry_ff;
   logic signed [pidl_pkg::DATA_W-1:0] entry_in;

   always_comb begin
      priority if (ctl.load) begin
         entry_in = item_value;
      end else if (ctl.from_left) begin
         entry_in = left_value;
      end else if (ctl.from_right) begin
         entry_in = right_value;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign tap_value   = ctl.tap ? entry_ff : '0;

endmodule

>>> design/positional_insert_delete_list_top.sv
// Channel  | Handshake           | Payload
// request  | req_valid/req_stall | req_cmd, req_position, req_item_value
// response | rsp_valid/rsp_stall | rsp_status, rsp_removed_value, rsp_list_count
//
// One request per cycle unless stalled: every cell of the chain shifts, loads
// or holds in the cycle of acceptance; the response follows in the next cycle.
// Reset clears the count and the response valid; cell contents stay undefined
// until written, and no response value depends on a cell beyond the count.
// A stalled response holds its register; req_stall is raised only then.
module positional_insert_delete_list_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_cmd,
   input  logic [pidl_pkg::POS_W-1:0]         req_position,
   input  logic signed [pidl_pkg::DATA_W-1:0] req_item_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic signed [pidl_pkg::DATA_W-1:0] rsp_removed_value,
   output logic [pidl_pkg::CNT_W-1:0]         rsp_list_count
);

   localparam logic [pidl_pkg::CNT_W-1:0] FULL_CNT = pidl_pkg::CNT_W'(pidl_pkg::DEPTH);

   logic                               accept;
   logic [pidl_pkg::CNT_W-1:0]         count_ff;
   logic [pidl_pkg::CNT_W-1:0]         count_in;
   logic                               full;
   logic                               pos_zero;
   logic [pidl_pkg::CNT_W:0]           count_p1;
   logic                               write_ok;
   logic                               del_ok;
   logic [pidl_pkg::CNT_W-1:0]         slot;
   pidl_pkg::status_type               status;

   logic                               rsp_valid_ff;
   logic [1:0]                         rsp_status_ff;
   logic signed [pidl_pkg::DATA_W-1:0] rsp_removed_ff;
   logic signed [pidl_pkg::DATA_W-1:0] removed;

   logic signed [pidl_pkg::DATA_W-1:0] entry [pidl_pkg::DEPTH];
   logic signed [pidl_pkg::DATA_W-1:0] tap   [pidl_pkg::DEPTH];
   pidl_pkg::cell_ctl_type             ctl   [pidl_pkg::DEPTH];

   // Hold a new request back only while the response register is stuck.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign full     = (count_ff == FULL_CNT);
   assign pos_zero = (req_position == '0);
   assign count_p1 = {1'b0, count_ff} + 1'b1;

   // Decode the operation: target slot (0-based) and outcome.
   // Full is checked before the position for an insert.
   always_comb begin
      write_ok = 1'b0;
      del_ok   = 1'b0;
      slot     = req_position - 1'b1;
      status   = pidl_pkg::ST_DONE;
      unique case (pidl_pkg::cmd_type'(req_cmd))
         pidl_pkg::CMD_APPEND: begin
            slot = count_ff;
            if (full) begin
               status = pidl_pkg::ST_FULL;
            end else begin
               write_ok = 1'b1;
            end
         end
         pidl_pkg::CMD_INSERT: begin
            if (full) begin
               status = pidl_pkg::ST_FULL;
            end else if (pos_zero || ({1'b0, req_position} > count_p1)) begin
               status = pidl_pkg::ST_BADPOS;
            end else begin
               write_ok = 1'b1;
            end
         end
         pidl_pkg::CMD_DELETE: begin
            if (pos_zero || (req_position > count_ff)) begin
               status = pidl_pkg::ST_BADPOS;
            end else begin
               del_ok = 1'b1;
            end
         end
         default: begin
            // unused command: no change, report done
         end
      endcase
   end

   // Chain of cells: each cell compares its own place with the target slot.
   // Insert/append: load at the slot, shift up above it.
   // Delete: shift down from the slot upward; tap the slot for the removed value.
   for (genvar g = 0; g < pidl_pkg::DEPTH; g++) begin : g_cell
      localparam logic [pidl_pkg::CNT_W-1:0] IDX = pidl_pkg::CNT_W'(g);
      logic signed [pidl_pkg::DATA_W-1:0] left_value;
      logic signed [pidl_pkg::DATA_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = entry[g-1];
      end
      if (g == pidl_pkg::DEPTH - 1) begin : g_last
         assign right_value = entry[g];
      end else begin : g_mid_r
         assign right_value = entry[g+1];
      end

      always_comb begin
         ctl[g].load       = accept & write_ok & (IDX == slot);
         ctl[g].from_left  = accept & write_ok & (IDX > slot);
         ctl[g].from_right = accept & del_ok & (IDX >= slot);
         ctl[g].tap        = del_ok & (IDX == slot);
      end

      pidl_cell u_cell (
         .clock       (clock),
         .ctl         (ctl[g]),
         .item_value  (req_item_value),
         .left_value  (left_value),
         .right_value (right_value),
         .entry_value (entry[g]),
         .tap_value   (tap[g])
      );
   end

   // At most one tap is live; merge the taps.
   always_comb begin
      removed = '0;
      for (int i = 0; i < pidl_pkg::DEPTH; i++) begin
         removed = removed | tap[i];
      end
   end

   // Update the count: up on a successful write, down on a successful delete.
   always_comb begin
      count_in = count_ff;
      if (accept && write_ok) begin
         count_in = count_p1[pidl_pkg::CNT_W-1:0];
      end else if (accept && del_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff  <= status;
         rsp_removed_ff <= removed;
      end
   end

   logic [pidl_pkg::CNT_W-1:0] rsp_count_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_list_count    = rsp_count_ff;

endmodule

>>> design/pidl_chk.sv
module pidl_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [1:0]                         rsp_status,
   input logic signed [pidl_pkg::DATA_W-1:0] rsp_removed_value,
   input logic [pidl_pkg::CNT_W-1:0]         rsp_list_count
);

   localparam logic [pidl_pkg::CNT_W-1:0] FULL_CNT = pidl_pkg::CNT_W'(pidl_pkg::DEPTH);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_removed_value) && $stable(rsp_list_count))
      else $error("stalled response changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stuck response");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_list_count <= FULL_CNT)
      else $error("list count beyond depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == 2'(pidl_pkg::ST_FULL) |-> rsp_list_count == FULL_CNT)
      else $error("full reported on a list that is not full");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 2'(pidl_pkg::ST_DONE) |-> rsp_removed_value == '0)
      else $error("removed value on a failed request");

endmodule

bind positional_insert_delete_list_top pidl_chk u_pidl_chk (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_list_count    (rsp_list_count)
);
